FILE: rtl/rgbpk_pkg.sv
// Shared types and constants for the RGB 10/12-bit pixel packer.
// Holds the beat payload structs, mode codes, sequencer phases and the byte swap.
// No dependencies.
package rgbpk_pkg;

	// Pixels per twelve-bit group; a group fills exactly nine words.
	localparam int GROUP_PIXELS = 8;
	localparam logic [2:0] GROUP_LAST = 3'(GROUP_PIXELS - 1);

	// Packing mode codes.
	localparam logic [2:0] MODE_10_XRGB_BE = 3'd0;
	localparam logic [2:0] MODE_10_RGBX_BE = 3'd1;
	localparam logic [2:0] MODE_10_RGBX_LE = 3'd2;
	localparam logic [2:0] MODE_12_BE      = 3'd3;
	localparam logic [2:0] MODE_12_LE      = 3'd4;

	// One input beat.
	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        end_of_row;
	} pix_t;

	// One output beat.
	typedef struct packed {
		logic [31:0] packed_word;
		logic        row_last;
	} word_t;

	// Word sequencer phase for the pixel held in the input stage.
	typedef enum logic [1:0] {
		PH_PIX,
		PH_HI,
		PH_PAD
	} phase_t;

	// Stream state kept between words.
	typedef struct packed {
		logic [31:0] carry;
		logic [2:0]  gp;
		phase_t      phase;
	} pack_state_t;

	// Result of one sequencer step.
	typedef struct packed {
		logic        emit;
		logic        done;
		word_t       word;
		pack_state_t nxt;
	} step_res_t;

	// Reverses the four bytes of a word.
	function automatic logic [31:0] swap_bytes(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

FILE: rtl/rgbpk_step.sv
// One step of the word sequencer: forms the next output word and the next stream state.
// Depends on rgbpk_pkg.
module rgbpk_step (
	input  logic [2:0]           mode,
	input  rgbpk_pkg::pix_t      pix,
	input  rgbpk_pkg::pack_state_t st,
	output rgbpk_pkg::step_res_t res
);
	import rgbpk_pkg::*;

	logic        is10;
	logic        is12;
	logic        big_endian;
	logic [9:0]  r10;
	logic [9:0]  g10;
	logic [9:0]  b10;
	logic [35:0] pix36;
	logic [4:0]  cnt;
	logic [63:0] acc;
	logic [31:0] word10;
	logic [31:0] word12;
	logic        at_last;
	pack_state_t nxt_st;

	// Mode decode and sample truncation.
	assign is10       = (mode == MODE_10_XRGB_BE) || (mode == MODE_10_RGBX_BE) ||
	                    (mode == MODE_10_RGBX_LE);
	assign is12       = (mode == MODE_12_BE) || (mode == MODE_12_LE);
	assign big_endian = (mode == MODE_12_BE);
	assign r10        = pix.red[15:6];
	assign g10        = pix.green[15:6];
	assign b10        = pix.blue[15:6];
	assign pix36      = {pix.blue[15:4], pix.green[15:4], pix.red[15:4]};
	assign at_last    = (st.gp == GROUP_LAST);

	// Stream accumulator: the carried bits count four per pixel already in the group.
	assign cnt = {st.gp, 2'b00};
	assign acc = {32'd0, st.carry} | ({28'd0, pix36} << cnt);

	// Next stream state.
	always_comb begin
		nxt_st = st;
		if (is12) begin
			unique case (st.phase)
				PH_PIX: begin
					nxt_st.carry = acc[63:32];
					if (at_last) begin
						nxt_st.gp    = '0;
						nxt_st.phase = PH_HI;
					end else begin
						nxt_st.gp    = 3'(st.gp + 3'd1);
						nxt_st.phase = pix.end_of_row ? PH_PAD : PH_PIX;
					end
				end
				PH_PAD: begin
					// A zero pixel flushes the carried bits; the group's final pixel
					// adds an all-zero word after them.
					nxt_st.carry = '0;
					if (at_last) begin
						nxt_st.gp    = '0;
						nxt_st.phase = PH_HI;
					end else begin
						nxt_st.gp    = 3'(st.gp + 3'd1);
						nxt_st.phase = PH_PAD;
					end
				end
				PH_HI: begin
					nxt_st.carry = '0;
					nxt_st.phase = PH_PIX;
				end
				default: nxt_st = st;
			endcase
		end
	end

	// Output word and item completion.
	always_comb begin
		unique case (mode)
			MODE_10_XRGB_BE: word10 = swap_bytes({2'b00, r10, g10, b10});
			MODE_10_RGBX_BE: word10 = swap_bytes({r10, g10, b10, 2'b00});
			default:         word10 = {r10, g10, b10, 2'b00};
		endcase
		word12 = (st.phase == PH_PIX) ? acc[31:0] : st.carry;
		if (big_endian) begin
			word12 = swap_bytes(word12);
		end

		res.nxt  = nxt_st;
		res.emit = is10 || is12;
		res.word = '{packed_word: word10, row_last: pix.end_of_row};
		res.done = 1'b1;
		if (is12) begin
			res.word.packed_word = word12;
			res.word.row_last    = (st.phase == PH_HI) && pix.end_of_row;
			unique case (st.phase)
				PH_PIX:  res.done = !at_last && !pix.end_of_row;
				PH_HI:   res.done = 1'b1;
				default: res.done = 1'b0;
			endcase
		end
	end

endmodule

FILE: rtl/rgb_10_12_bit_pixel_packer.sv
// RGB 10/12-bit pixel packer top level: input stage, word sequencer state, output register.
// Depends on rgbpk_pkg and rgbpk_step.
//
// Takes one pixel beat (three 16-bit samples and an end-of-row flag) and emits 32-bit
// packed words, one per output beat. Ten-bit modes give one word per pixel, so a new
// pixel is taken every cycle unless stalled. Twelve-bit modes give one word per pixel
// and two for the eighth pixel of a group, so a group of eight pixels gives nine words;
// at the end of a row a partial group is padded with zero pixels and its remaining
// words follow, one per cycle unless stalled, with row_last on the final word. Reserved
// modes 5 to 7 drop pixels silently. The rate is set by the single output word per
// cycle: unless stalled, the sequencer emits one word per cycle from the pixel held in
// the input stage, and the next pixel enters that stage in the cycle its predecessor's
// last word is taken. A write to pack_mode discards any partial group.
module rgb_10_12_bit_pixel_packer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rgbpk_pkg::pix_t   in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output rgbpk_pkg::word_t  out_data,
	input  logic              cfg_write_en,
	input  logic [2:0]        cfg_write_data
);
	import rgbpk_pkg::*;

	logic [2:0]  pack_mode_q;
	pix_t        pix_s1;
	logic        valid_s1;
	pack_state_t st_q;
	step_res_t   res;
	logic        out_valid_q;
	word_t       out_q;
	logic        out_free;
	logic        step;
	logic        done;
	logic        in_accept;

	rgbpk_step u_step (
		.mode (pack_mode_q),
		.pix  (pix_s1),
		.st   (st_q),
		.res  (res)
	);

	// Handshake: the sequencer steps when its word has somewhere to go.
	assign out_free  = !out_valid_q || !out_stall;
	assign step      = valid_s1 && (!res.emit || out_free);
	assign done      = step && res.done;
	assign in_stall  = valid_s1 && !done;
	assign in_accept = in_valid && !in_stall;

	// Mode register and stream state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_mode_q <= MODE_10_XRGB_BE;
			st_q        <= '{carry: '0, gp: '0, phase: PH_PIX};
		end else if (cfg_write_en) begin
			pack_mode_q <= cfg_write_data;
			st_q        <= '{carry: '0, gp: '0, phase: PH_PIX};
		end else if (step) begin
			st_q <= res.nxt;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1 <= in_data;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			out_q <= res.word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// Only bits of pixels already in the group may be carried between pixels.
	a_carry_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_PIX) |-> ((st_q.carry >> {st_q.gp, 2'b00}) == 32'd0))
		else $error("carry holds bits beyond the group position");

	// The high word of a group is always its last, so the group position is back at zero.
	a_hi_at_group_start: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_HI) |-> (st_q.gp == 3'd0))
		else $error("high-word phase away from group start");

	// Padding runs only for a held end-of-row pixel inside a partial group.
	a_pad_context: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_PAD) |-> (valid_s1 && pix_s1.end_of_row && (st_q.gp != 3'd0)))
		else $error("padding without an end-of-row pixel");

	// A word is never overwritten while it waits to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(step && res.emit))
		else $error("output word overwritten under stall");

	// The input stage is free whenever it holds no pixel.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall raised with an empty input stage");
`endif

endmodule

FILE: sim/rgbpk_word_checker.sv
// Checker for the RGB 10/12-bit pixel packer: predicts packed words from pixel beats and
// compares them with the word beats that come out. Depends on rgbpk_pkg.
module rgbpk_word_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  rgbpk_pkg::pix_t  in_data,
	input  logic             out_valid,
	input  logic             out_stall,
	input  rgbpk_pkg::word_t out_data,
	input  logic             cfg_write_en,
	input  logic [2:0]       cfg_write_data,
	output int unsigned      fail_count,
	output int unsigned      words_pending,
	output int unsigned      words_checked
);
	import rgbpk_pkg::*;

	// Shadow copy of the mode register and the twelve-bit stream state.
	logic [2:0]  mode;
	logic [31:0] carry;
	logic [4:0]  carry_cnt;
	logic [2:0]  grp;
	word_t       want_words[$];

	// Byte order reversal for the big-endian layouts.
	function automatic logic [31:0] reverse_bytes(input logic [31:0] w);
		logic [31:0] r;
		for (int i = 0; i < 4; i++) begin
			r[8*i +: 8] = w[8*(3-i) +: 8];
		end
		return r;
	endfunction

	// Appends one 36-bit pixel to the LSB-first stream and queues every full word.
	task automatic append_stream(input logic [35:0] pix, input bit big);
		logic [63:0] acc;
		int unsigned fill;
		word_t w;
		fill = carry_cnt;
		acc = {32'd0, carry} | ({28'd0, pix} << fill);
		fill += 36;
		while (fill >= 32) begin
			w.packed_word = big ? reverse_bytes(acc[31:0]) : acc[31:0];
			w.row_last = 1'b0;
			want_words.push_back(w);
			acc = acc >> 32;
			fill -= 32;
		end
		carry = acc[31:0];
		carry_cnt = 5'(fill);
		grp = grp + 3'd1;
	endtask

	// Works out the words that one accepted pixel beat causes.
	task automatic predict_pixel(input pix_t p);
		logic [9:0] r10, g10, b10;
		word_t w;
		bit big;
		r10 = p.red[15:6];
		g10 = p.green[15:6];
		b10 = p.blue[15:6];
		w.row_last = p.end_of_row;
		case (mode)
			MODE_10_XRGB_BE: begin
				w.packed_word = reverse_bytes({2'b00, r10, g10, b10});
				want_words.push_back(w);
			end
			MODE_10_RGBX_BE: begin
				w.packed_word = reverse_bytes({r10, g10, b10, 2'b00});
				want_words.push_back(w);
			end
			MODE_10_RGBX_LE: begin
				w.packed_word = {r10, g10, b10, 2'b00};
				want_words.push_back(w);
			end
			MODE_12_BE, MODE_12_LE: begin
				big = (mode == MODE_12_BE);
				append_stream({p.blue[15:4], p.green[15:4], p.red[15:4]}, big);
				if (p.end_of_row) begin
					// Pad the group with zero pixels and flag its final word.
					while (grp != 3'd0) begin
						append_stream(36'd0, big);
					end
					w = want_words.pop_back();
					w.row_last = 1'b1;
					want_words.push_back(w);
				end
			end
			default: begin
				// Reserved modes drop the pixel and keep the state.
			end
		endcase
	endtask

	// Compare the word beat first, then apply a mode write, then predict the pixel beat.
	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			mode = MODE_10_XRGB_BE;
			carry = '0;
			carry_cnt = '0;
			grp = '0;
			want_words.delete();
			fail_count = 0;
			words_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (want_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("checker: unexpected word %h row_last %b",
							out_data.packed_word, out_data.row_last);
					end
				end else begin
					want = want_words.pop_front();
					words_checked++;
					if (out_data.packed_word !== want.packed_word ||
							out_data.row_last !== want.row_last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("checker: word %0d expected %h row_last %b, got %h row_last %b",
								words_checked, want.packed_word, want.row_last,
								out_data.packed_word, out_data.row_last);
						end
					end
				end
			end
			if (cfg_write_en) begin
				mode = cfg_write_data;
				carry = '0;
				carry_cnt = '0;
				grp = '0;
			end
			if (in_valid && !in_stall) begin
				predict_pixel(in_data);
			end
		end
		words_pending = want_words.size();
	end

endmodule

FILE: sim/tb.sv
// Testbench top for the RGB 10/12-bit pixel packer: clock, reset, pixel stimulus,
// output stalls and the verdict. Depends on rgbpk_pkg, the packer and rgbpk_word_checker.
module tb;
	import rgbpk_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_PIXELS = 310;
	localparam int unsigned CALM_TAIL = 40;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam logic [2:0] MODE_RSVD_LO = 3'd5;
	localparam logic [2:0] MODE_RSVD_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	pix_t        in_data;
	logic        out_valid;
	logic        out_stall;
	word_t       out_data;
	logic        cfg_write_en;
	logic [2:0]  cfg_write_data;

	int unsigned fail_count;
	int unsigned words_pending;
	int unsigned words_checked;
	int unsigned cycle_count = 0;
	int unsigned pixels_packed = 0;
	int unsigned pixels_dropped = 0;
	logic [2:0]  cur_mode = MODE_10_XRGB_BE;
	logic [7:0]  modes_written = '0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;

	rgb_10_12_bit_pixel_packer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	rgbpk_word_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.fail_count     (fail_count),
		.words_pending  (words_pending),
		.words_checked  (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Output side stalls in random bursts unless told to stay quiet.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!rx_calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Sample value that favors the extremes now and then.
	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Sends one pixel beat, with an optional idle burst ahead of it.
	task automatic drive_pixel(input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b, input logic eor);
		pix_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.end_of_row = eor;
		if (!tx_calm && $urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 9)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (in_stall);
		if (cur_mode <= MODE_12_LE) pixels_packed++;
		else pixels_dropped++;
	endtask

	// Holds the input idle until every predicted word has come out.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_pending != 0) @(negedge clk);
	endtask

	// Writes the mode register once the block has gone quiet.
	task automatic write_mode(input logic [2:0] m);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= m;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		cur_mode = m;
		modes_written[m] = 1'b1;
	endtask

	// One row of random pixels; a stray end-of-row or a missing one now and then.
	task automatic random_row(input int unsigned len, input bit close);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 59) == 0) wait_drained();
			drive_pixel(rand_sample(), rand_sample(), rand_sample(),
				(i == len - 1) ? close : ($urandom_range(0, 29) == 0));
		end
	endtask

	initial begin
		int unsigned base;
		int unsigned rows;
		int unsigned len;
		logic [2:0] m;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Ten-bit layouts with extreme and patterned samples; low bits must be dropped.
		write_mode(MODE_10_XRGB_BE);
		drive_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
		drive_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		drive_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
		drive_pixel(16'hAAAA, 16'h5555, 16'h003F, 1'b1);
		write_mode(MODE_10_RGBX_BE);
		drive_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		drive_pixel(16'h5555, 16'hAAAA, 16'hFFC0, 1'b1);
		write_mode(MODE_10_RGBX_LE);
		drive_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
		drive_pixel(16'h8040, 16'h7FFF, 16'hFFFF, 1'b1);

		// Twelve-bit big-endian: a short row padded out, then a full group.
		write_mode(MODE_12_BE);
		drive_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		drive_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
		drive_pixel(16'hFFF0, 16'h000F, 16'hA5A5, 1'b1);
		for (int unsigned i = 0; i < 8; i++) begin
			drive_pixel(rand_sample(), rand_sample(), rand_sample(), i == 7);
		end

		// Twelve-bit little-endian: a one-pixel row, then a row paused mid-group.
		write_mode(MODE_12_LE);
		drive_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		drive_pixel(16'hFEDC, 16'hBA98, 16'h7654, 1'b0);
		drive_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
		wait_drained();
		drive_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);

		// Reserved mode drops pixels; a mode write then discards a partial group.
		write_mode(MODE_RSVD_HI);
		drive_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		drive_pixel(16'h1111, 16'h2222, 16'h3333, 1'b1);
		write_mode(MODE_12_LE);
		drive_pixel(16'hC3C3, 16'h3C3C, 16'hFFFF, 1'b0);
		write_mode(MODE_RSVD_LO);

		// Random phases: one mode each, mostly well-formed rows with random content.
		base = pixels_packed;
		while (pixels_packed - base < RANDOM_PIXELS) begin
			if (pixels_packed - base >= RANDOM_PIXELS - CALM_TAIL) begin
				tx_calm = 1'b1;
				rx_calm = 1'b1;
			end else begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 9) == 0) m = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
			else m = 3'($urandom_range(MODE_10_XRGB_BE, MODE_12_LE));
			write_mode(m);
			if (m > MODE_12_LE) begin
				random_row(3, 1'b1);
			end else begin
				rows = $urandom_range(1, 4);
				repeat (rows) begin
					len = ($urandom_range(0, 2) == 0) ? 8 * $urandom_range(1, 2)
						: $urandom_range(1, 13);
					random_row(len, $urandom_range(0, 9) != 0);
				end
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("tb: %0d pixels packed, %0d dropped in reserved modes, %0d words checked",
			pixels_packed, pixels_dropped, words_checked);
		$display("tb: pack mode values written (bit per code): %b", modes_written);
		if (fail_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
